@@ hdl/rpsm_pkg.sv @@
package rpsm_pkg;

    localparam int PIC_W  = 32;
    localparam int TAG_W  = 16;
    localparam int AGE_W  = 32;
    localparam int WORD_W = PIC_W + TAG_W + AGE_W;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_REF    = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic eval_en;
        logic commit;
    } rpsm_cmd_t;

    typedef struct packed {
        logic out_free;
    } rpsm_stat_t;

endpackage

@@ hdl/reference_picture_slot_manager_unit.sv @@
// A result is offered once the input is loaded, the scan has read every slot entry from
// the slot memory, one per cycle, and the drain and commit states have passed. A new item
// is taken only after the last one has committed.
// A waiting result does not block the next input transfer, but it holds back
// the commit of that item and so the transfer after it.
// Reset is asynchronous and active low and clears all slot marks, the age and the current slot.
module reference_picture_slot_manager_unit
    import rpsm_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       opcode,
    input  logic [PIC_W-1:0] pic_id,
    input  logic [TAG_W-1:0] tag,
    input  logic             pic_invalid,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [3:0]       slot_index,
    output logic             hit,
    output logic [1:0]       status
);

    localparam int IDX_W = $clog2(SLOTS);

    rpsm_cmd_t        cmd;
    rpsm_stat_t       stat;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] eval_idx;

    rpsm_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .stat    (stat),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .eval_idx(eval_idx)
    );

    rpsm_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .rd_addr    (rd_addr),
        .eval_idx   (eval_idx),
        .opcode     (opcode),
        .pic_id     (pic_id),
        .tag        (tag),
        .pic_invalid(pic_invalid),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot_index (slot_index),
        .hit        (hit),
        .status     (status)
    );

endmodule

@@ hdl/rpsm_ram.sv @@
module rpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/rpsm_ctrl.sv @@
module rpsm_ctrl
    import rpsm_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  rpsm_stat_t               stat,
    output rpsm_cmd_t                cmd,
    output logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic [$clog2(SLOTS)-1:0] eval_idx
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             eval_en_reg;
    logic [IDX_W-1:0] eval_idx_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.load    = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.eval_en = eval_en_reg;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            eval_en_reg  <= 1'b0;
            eval_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            eval_en_reg  <= cmd.rd_en;
            eval_idx_reg <= cnt_reg;
        end
    end

    assign rd_addr     = cnt_reg;
    assign eval_idx    = eval_idx_reg;
    assign in_stall    = (state_reg != S_IDLE);

endmodule

@@ hdl/rpsm_dp.sv @@
module rpsm_dp
    import rpsm_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rpsm_cmd_t                cmd,
    output rpsm_stat_t               stat,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    input  logic [$clog2(SLOTS)-1:0] eval_idx,
    input  logic [1:0]               opcode,
    input  logic [PIC_W-1:0]         pic_id,
    input  logic [TAG_W-1:0]         tag,
    input  logic                     pic_invalid,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [3:0]               slot_index,
    output logic                     hit,
    output logic [1:0]               status
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [1:0]       op_reg;
    logic [PIC_W-1:0] id_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             inv_reg;

    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] rsv_reg, rsv_next;
    logic [AGE_W-1:0] gage_reg, gage_next;
    logic [IDX_W-1:0] cur_reg, cur_next;

    logic             mfound_reg, mfound_next;
    logic [IDX_W-1:0] midx_reg, midx_next;
    logic             ffound_reg, ffound_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;
    logic             bfound_reg, bfound_next;
    logic [IDX_W-1:0] bidx_reg, bidx_next;
    logic [AGE_W-1:0] bage_reg, bage_next;

    logic             out_valid_reg;
    logic [3:0]       slot_reg;
    logic             hit_reg;
    logic [1:0]       status_reg;

    logic [WORD_W-1:0] rdata;
    logic [PIC_W-1:0]  rd_pic;
    logic [AGE_W-1:0]  rd_age;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;

    logic             alloc_found;
    logic [IDX_W-1:0] alloc_idx;
    logic [IDX_W-1:0] res_slot;
    logic [IDX_W+3:0] res_slot_ext;
    logic             res_hit;
    logic [1:0]       res_status;

    rpsm_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    assign rd_pic = rdata[WORD_W-1 -: PIC_W];
    assign rd_age = rdata[AGE_W-1:0];

    // Scan evaluation: first match, first free slot, oldest unused slot.
    always_comb
    begin
        mfound_next = mfound_reg;
        midx_next   = midx_reg;
        ffound_next = ffound_reg;
        fidx_next   = fidx_reg;
        bfound_next = bfound_reg;
        bidx_next   = bidx_reg;
        bage_next   = bage_reg;
        if (cmd.load)
        begin
            mfound_next = 1'b0;
            ffound_next = 1'b0;
            bfound_next = 1'b0;
        end
        else if (cmd.eval_en)
        begin
            if (!mfound_reg && valid_reg[eval_idx] && (rd_pic == id_reg))
            begin
                mfound_next = 1'b1;
                midx_next   = eval_idx;
            end
            if (!ffound_reg && !valid_reg[eval_idx] && !rsv_reg[eval_idx])
            begin
                ffound_next = 1'b1;
                fidx_next   = eval_idx;
            end
            if (valid_reg[eval_idx] && !used_reg[eval_idx] && !rsv_reg[eval_idx]
                && (!bfound_reg || (rd_age < bage_reg)))
            begin
                bfound_next = 1'b1;
                bidx_next   = eval_idx;
                bage_next   = rd_age;
            end
        end
    end

    assign alloc_found = ffound_reg || bfound_reg;
    assign alloc_idx   = ffound_reg ? fidx_reg : bidx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        rsv_next   = rsv_reg;
        gage_next  = gage_reg;
        cur_next   = cur_reg;
        we         = 1'b0;
        waddr      = alloc_idx;
        wdata      = {id_reg, tag_reg, gage_reg};
        res_slot   = '0;
        res_hit    = 1'b0;
        res_status = ST_DONE;
        case (op_reg)
            OP_BEGIN:
            begin
                if (mfound_reg || alloc_found)
                begin
                    res_slot = mfound_reg ? midx_reg : alloc_idx;
                    res_hit  = mfound_reg;
                    valid_next[res_slot] = 1'b0;
                    rsv_next[res_slot]   = 1'b1;
                    cur_next = res_slot;
                end
                else
                begin
                    res_status = ST_NO_SLOT;
                end
                gage_next = gage_reg + 1'b1;
                used_next = '0;
            end
            OP_REF:
            begin
                if (inv_reg)
                begin
                    res_status = ST_SKIPPED;
                end
                else if (mfound_reg)
                begin
                    we       = 1'b1;
                    waddr    = midx_reg;
                    res_slot = midx_reg;
                    res_hit  = 1'b1;
                    used_next[midx_reg] = 1'b1;
                end
                else if (alloc_found)
                begin
                    we       = 1'b1;
                    waddr    = alloc_idx;
                    res_slot = alloc_idx;
                    valid_next[alloc_idx] = 1'b1;
                    used_next[alloc_idx]  = 1'b1;
                    rsv_next[alloc_idx]   = 1'b0;
                end
                else
                begin
                    res_status = ST_NO_SLOT;
                end
            end
            OP_LOOKUP:
            begin
                if (mfound_reg)
                begin
                    res_slot = midx_reg;
                    res_hit  = 1'b1;
                end
            end
            OP_FINISH:
            begin
                if (inv_reg)
                begin
                    res_status = ST_SKIPPED;
                end
                else if (mfound_reg)
                begin
                    res_slot   = midx_reg;
                    res_hit    = 1'b1;
                    res_status = ST_SKIPPED;
                end
                else if (rsv_reg[cur_reg])
                begin
                    we       = 1'b1;
                    waddr    = cur_reg;
                    res_slot = cur_reg;
                    valid_next[cur_reg] = 1'b1;
                    used_next[cur_reg]  = 1'b1;
                    rsv_next[cur_reg]   = 1'b0;
                end
                else
                begin
                    res_status = ST_NO_SLOT;
                end
            end
            default:
            begin
                res_status = ST_DONE;
            end
        endcase
        if (!cmd.commit)
        begin
            we         = 1'b0;
            valid_next = valid_reg;
            used_next  = used_reg;
            rsv_next   = rsv_reg;
            gage_next  = gage_reg;
            cur_next   = cur_reg;
        end
    end

    assign res_slot_ext = {4'b0000, res_slot};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            id_reg  <= pic_id;
            tag_reg <= tag;
            inv_reg <= pic_invalid;
        end
        midx_reg <= midx_next;
        fidx_reg <= fidx_next;
        bidx_reg <= bidx_next;
        bage_reg <= bage_next;
        if (cmd.commit)
        begin
            slot_reg   <= res_slot_ext[3:0];
            hit_reg    <= res_hit;
            status_reg <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            used_reg      <= '0;
            rsv_reg       <= '0;
            gage_reg      <= '0;
            cur_reg       <= '0;
            mfound_reg    <= 1'b0;
            ffound_reg    <= 1'b0;
            bfound_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            used_reg   <= used_next;
            rsv_reg    <= rsv_next;
            gage_reg   <= gage_next;
            cur_reg    <= cur_next;
            mfound_reg <= mfound_next;
            ffound_reg <= ffound_next;
            bfound_reg <= bfound_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign slot_index    = slot_reg;
    assign hit           = hit_reg;
    assign status        = status_reg;

endmodule

@@ test/testbench.sv @@
module testbench
    import rpsm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic [3:0] slot;
        logic       hit;
        logic [1:0] st;
    } slot_result_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [PIC_W-1:0] pic;
        logic [TAG_W-1:0] tg;
        logic             inv;
        logic             typed;
        slot_result_t     want;
    } directed_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       opcode = OP_LOOKUP;
    logic [PIC_W-1:0] pic_id = '0;
    logic [TAG_W-1:0] tag = '0;
    logic             pic_invalid = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [3:0]       slot_index;
    logic             hit;
    logic [1:0]       status;

    reference_picture_slot_manager_unit #(.SLOTS(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .pic_id(pic_id),
        .tag(tag),
        .pic_invalid(pic_invalid),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .slot_index(slot_index),
        .hit(hit),
        .status(status)
    );

    // Predicted slot table.
    logic [PIC_W-1:0] dpb_picture [SLOTS];
    logic [TAG_W-1:0] dpb_tag [SLOTS];
    logic [AGE_W-1:0] dpb_age [SLOTS];
    logic             dpb_valid [SLOTS];
    logic             dpb_used [SLOTS];
    logic             dpb_reserved [SLOTS];
    logic [AGE_W-1:0] frame_age = '0;
    int               current_slot = 0;

    slot_result_t     pending_results[$];
    directed_row_t    stimulus_rows[$];
    logic [PIC_W-1:0] picture_pool [POOL_SIZE];

    int idle_pct = 0;
    int stall_pct = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int no_slot_count = 0;
    int hit_count = 0;

    always #4 clk = ~clk;

    function automatic int find_picture_slot(input logic [PIC_W-1:0] id);
        for (int i = 0; i < SLOTS; i++) begin
            if (dpb_valid[i] && dpb_picture[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int choose_victim_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!dpb_valid[i] && !dpb_reserved[i]) begin
                return i;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!dpb_used[i] && !dpb_reserved[i]) begin
                if (best < 0 || dpb_age[i] < dpb_age[best]) begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    function automatic void store_picture(input int s, input logic [PIC_W-1:0] id,
                                          input logic [TAG_W-1:0] tg);
        dpb_picture[s] = id;
        dpb_tag[s] = tg;
        dpb_age[s] = frame_age;
        dpb_valid[s] = 1'b1;
        dpb_used[s] = 1'b1;
        dpb_reserved[s] = 1'b0;
    endfunction

    function automatic slot_result_t apply_item(input logic [1:0] op,
                                                input logic [PIC_W-1:0] id,
                                                input logic [TAG_W-1:0] tg,
                                                input logic inv);
        slot_result_t r;
        int s;
        r = '0;
        r.st = ST_DONE;
        s = find_picture_slot(id);
        case (op)
            OP_BEGIN: begin
                if (s >= 0) begin
                    r.hit = 1'b1;
                end else begin
                    s = choose_victim_slot();
                end
                if (s >= 0) begin
                    dpb_picture[s] = '0;
                    dpb_tag[s] = '0;
                    dpb_age[s] = '0;
                    dpb_valid[s] = 1'b0;
                    dpb_used[s] = 1'b0;
                    dpb_reserved[s] = 1'b1;
                    current_slot = s;
                    r.slot = 4'(s);
                end else begin
                    r.st = ST_NO_SLOT;
                end
                frame_age = frame_age + 1'b1;
                for (int i = 0; i < SLOTS; i++) begin
                    dpb_used[i] = 1'b0;
                end
            end
            OP_REF: begin
                if (inv) begin
                    r.st = ST_SKIPPED;
                end else if (s >= 0) begin
                    dpb_age[s] = frame_age;
                    dpb_used[s] = 1'b1;
                    r.slot = 4'(s);
                    r.hit = 1'b1;
                end else begin
                    s = choose_victim_slot();
                    if (s >= 0) begin
                        store_picture(s, id, tg);
                        r.slot = 4'(s);
                    end else begin
                        r.st = ST_NO_SLOT;
                    end
                end
            end
            OP_LOOKUP: begin
                if (s >= 0) begin
                    r.slot = 4'(s);
                    r.hit = 1'b1;
                end
            end
            default: begin
                if (inv) begin
                    r.st = ST_SKIPPED;
                end else if (s >= 0) begin
                    r.slot = 4'(s);
                    r.hit = 1'b1;
                    r.st = ST_SKIPPED;
                end else if (dpb_reserved[current_slot]) begin
                    store_picture(current_slot, id, tg);
                    r.slot = 4'(current_slot);
                end else begin
                    r.st = ST_NO_SLOT;
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [PIC_W-1:0] id,
                           input logic [TAG_W-1:0] tg, input logic inv,
                           input logic typed, input slot_result_t want);
        directed_row_t row;
        row.op = op;
        row.pic = id;
        row.tg = tg;
        row.inv = inv;
        row.typed = typed;
        row.want = want;
        stimulus_rows.push_back(row);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [PIC_W-1:0] id,
                             input logic [TAG_W-1:0] tg, input logic inv,
                             input logic typed, input slot_result_t want);
        slot_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        pic_id <= id;
        tag <= tg;
        pic_invalid <= inv;
        do begin
            @(posedge clk);
        end while (in_stall);
        predicted = apply_item(op, id, tg, inv);
        pending_results.push_back(typed ? want : predicted);
        items_accepted++;
    endtask

    function automatic logic [PIC_W-1:0] pick_picture();
        if ($urandom_range(99) < 85) begin
            return picture_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    task automatic run_frame();
        logic [PIC_W-1:0] frame_pic;
        int refs;
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            send_item(2'($urandom_range(3)), pick_picture(), 16'($urandom),
                      1'($urandom_range(1)), 1'b0, '0);
            return;
        end
        frame_pic = pick_picture();
        send_item(OP_BEGIN, frame_pic, 16'($urandom), 1'($urandom_range(1)), 1'b0, '0);
        refs = (roll < 25) ? $urandom_range(20) : $urandom_range(6);
        for (int k = 0; k < refs; k++) begin
            if ($urandom_range(3) == 0) begin
                send_item(OP_LOOKUP, ($urandom_range(3) == 0) ? frame_pic : pick_picture(),
                          16'($urandom), 1'($urandom_range(1)), 1'b0, '0);
            end
            send_item(OP_REF, pick_picture(), 16'($urandom),
                      $urandom_range(9) == 0, 1'b0, '0);
        end
        if (roll < 90) begin
            send_item(OP_FINISH, ($urandom_range(9) == 0) ? pick_picture() : frame_pic,
                      16'($urandom), $urandom_range(9) == 0, 1'b0, '0);
        end
        if (roll >= 95) begin
            send_item(OP_FINISH, frame_pic, 16'($urandom), 1'b0, 1'b0, '0);
        end
    endtask

    task automatic run_traffic(input int count, input int idle, input int stall);
        int target;
        idle_pct = idle;
        stall_pct = stall;
        target = items_accepted + count;
        while (items_accepted < target) begin
            run_frame();
        end
    endtask

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        slot_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: expected no result, actual slot %0d hit %0d status %0d",
                         $time, slot_index, hit, status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.st == ST_NO_SLOT) begin
                    no_slot_count++;
                end
                if (want.hit) begin
                    hit_count++;
                end
                if (slot_index !== want.slot) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, slot_index);
                    mismatch_count++;
                end
                if (hit !== want.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
                    mismatch_count++;
                end
                if (status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        directed_row_t row;
        for (int i = 0; i < SLOTS; i++) begin
            dpb_picture[i] = '0;
            dpb_tag[i] = '0;
            dpb_age[i] = '0;
            dpb_valid[i] = 1'b0;
            dpb_used[i] = 1'b0;
            dpb_reserved[i] = 1'b0;
        end
        picture_pool[0] = '0;
        picture_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            picture_pool[i] = $urandom;
        end

        // The run fills the table, then forces both allocation failures and
        // the refresh, re-begin and duplicate-finish paths.
        add_row(OP_LOOKUP, 32'h0, 16'h0, 1'b0, 1'b1, '{4'd0, 1'b0, ST_DONE});
        add_row(OP_FINISH, 32'h5, 16'h1, 1'b0, 1'b1, '{4'd0, 1'b0, ST_NO_SLOT});
        add_row(OP_REF, 32'h7, 16'h2, 1'b1, 1'b1, '{4'd0, 1'b0, ST_SKIPPED});
        add_row(OP_BEGIN, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, '{4'd0, 1'b0, ST_DONE});
        add_row(OP_FINISH, 32'h0, 16'h0, 1'b1, 1'b1, '{4'd0, 1'b0, ST_SKIPPED});
        for (int k = 1; k < SLOTS; k++) begin
            add_row(OP_REF, 32'h1000 + k, TAG_W'(k * 'h1111), 1'b0, 1'b0, '0);
        end
        add_row(OP_REF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, '{4'd0, 1'b0, ST_NO_SLOT});
        add_row(OP_FINISH, 32'h0, 16'hFFFF, 1'b0, 1'b0, '0);
        add_row(OP_FINISH, 32'h0, 16'h0, 1'b0, 1'b0, '0);
        add_row(OP_BEGIN, 32'hDEAD_BEEF, 16'h0, 1'b0, 1'b1, '{4'd0, 1'b0, ST_NO_SLOT});
        add_row(OP_BEGIN, 32'h1003, 16'h0, 1'b0, 1'b0, '0);
        add_row(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 1'b1, 1'b1, '{4'd0, 1'b0, ST_DONE});
        add_row(OP_REF, 32'h1002, 16'h0, 1'b0, 1'b0, '0);
        add_row(OP_LOOKUP, 32'h0, 16'hFFFF, 1'b0, 1'b0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stimulus_rows[n]) begin
            row = stimulus_rows[n];
            send_item(row.op, row.pic, row.tg, row.inv, row.typed, row.want);
        end

        run_traffic(265, 0, 0);
        run_traffic(260, 83, 0);
        run_traffic(260, 0, 83);
        run_traffic(260, 25, 25);

        @(negedge clk);
        in_valid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SLOTS + 10) @(posedge clk);

        $display("Sent %0d items over four idle and stall mixes; checked %0d results.",
                 items_accepted, results_checked);
        $display("Results with a matching picture: %0d; with no free slot: %0d.",
                 hit_count, no_slot_count);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
